@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL files.
// Define ASSERT_OFF to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// A property checked at every rising clock edge outside reset.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ hdl/fpw_pkg.sv @@
package fpw_pkg;

    localparam int FPW_POS_W    = 16;
    localparam int FPW_LEVEL_W  = 8;
    localparam int FPW_STRIDE_W = 20;
    localparam int FPW_PB_W     = 4;
    localparam int FPW_WORD_W   = 32;
    localparam int FPW_INDEX_W  = 4;
    localparam int FPW_QDEPTH   = 4;
    localparam int FPW_QCNT_W   = $clog2(FPW_QDEPTH + 1);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FRAME = 2'd1,
        ST_BOUNDS   = 2'd2,
        ST_FORMAT   = 2'd3
    } fpw_status_t;

    typedef enum logic [1:0] {
        FMT_BGR  = 2'd0,
        FMT_RGB  = 2'd1,
        FMT_MASK = 2'd2,
        FMT_NONE = 2'd3
    } fpw_format_t;

    localparam logic [FPW_INDEX_W-1:0] REG_FRAME_PRESENT = 4'd0;
    localparam logic [FPW_INDEX_W-1:0] REG_LINE_STRIDE   = 4'd1;
    localparam logic [FPW_INDEX_W-1:0] REG_PIXEL_BYTES   = 4'd2;
    localparam logic [FPW_INDEX_W-1:0] REG_BUFFER_SIZE   = 4'd3;
    localparam logic [FPW_INDEX_W-1:0] REG_FORMAT_MODE   = 4'd4;
    localparam logic [FPW_INDEX_W-1:0] REG_RED_MASK      = 4'd5;
    localparam logic [FPW_INDEX_W-1:0] REG_GREEN_MASK    = 4'd6;
    localparam logic [FPW_INDEX_W-1:0] REG_BLUE_MASK     = 4'd7;

    typedef struct packed {
        logic                    frame_present;
        logic [FPW_STRIDE_W-1:0] line_stride_bytes;
        logic [FPW_PB_W-1:0]     pixel_bytes;
        logic [FPW_WORD_W-1:0]   buffer_size_bytes;
        fpw_format_t             format_mode;
        logic [FPW_WORD_W-1:0]   red_bit_mask;
        logic [FPW_WORD_W-1:0]   green_bit_mask;
        logic [FPW_WORD_W-1:0]   blue_bit_mask;
    } fpw_cfg_t;

    localparam fpw_cfg_t FPW_CFG_RST = '{
        frame_present:     1'b0,
        line_stride_bytes: '0,
        pixel_bytes:       4'd4,
        buffer_size_bytes: '0,
        format_mode:       FMT_BGR,
        red_bit_mask:      '0,
        green_bit_mask:    '0,
        blue_bit_mask:     '0
    };

    typedef struct packed {
        logic [FPW_WORD_W-1:0]  offset;
        fpw_status_t            status;
        logic [FPW_LEVEL_W-1:0] red;
        logic [FPW_LEVEL_W-1:0] green;
        logic [FPW_LEVEL_W-1:0] blue;
    } fpw_req_t;

endpackage

@@ hdl/fpw_queue.sv @@
`include "assert_macros.svh"

module fpw_queue
    import fpw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  fpw_req_t              wdata,
    input  logic                  pop,
    output fpw_req_t              rdata,
    output logic                  not_empty,
    output logic [FPW_QCNT_W-1:0] count
);

    localparam int PTR_W = $clog2(FPW_QDEPTH);

    fpw_req_t             mem_reg [FPW_QDEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [FPW_QCNT_W-1:0] count_reg;
    logic [FPW_QCNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FPW_QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FPW_QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata     = mem_reg[rd_ptr_reg];
    assign count     = count_reg;
    assign not_empty = (count_reg != '0);

    `ASSERT_CLK_RST(a_no_overflow, clk, rst_n,
        !(push && !pop && (count_reg == FPW_QCNT_W'(FPW_QDEPTH))),
        "Queue written while full.")
    `ASSERT_CLK_RST(a_no_underflow, clk, rst_n, !(pop && (count_reg == '0)),
        "Queue read while empty.")
    `ASSERT_CLK_RST(a_ptr_match, clk, rst_n,
        ((count_reg == '0) || (count_reg == FPW_QCNT_W'(FPW_QDEPTH))) |->
            (wr_ptr_reg == rd_ptr_reg),
        "Queue pointers disagree with the fill count.")

endmodule

@@ hdl/fpw_front.sv @@
module fpw_front
    import fpw_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  fpw_cfg_t               cfg,
    input  logic                   push,
    output logic                   full,
    input  logic [FPW_POS_W-1:0]   pos_x,
    input  logic [FPW_POS_W-1:0]   pos_y,
    input  logic [FPW_LEVEL_W-1:0] red_level,
    input  logic [FPW_LEVEL_W-1:0] green_level,
    input  logic [FPW_LEVEL_W-1:0] blue_level,
    input  logic [FPW_QCNT_W-1:0]  q_count,
    output logic                   q_push,
    output fpw_req_t               q_data
);

    localparam int CW    = (COORD_BITS < FPW_POS_W) ? COORD_BITS : FPW_POS_W;
    localparam int PY_W  = CW + FPW_STRIDE_W;
    localparam int PX_W  = CW + FPW_PB_W;
    localparam int OFF_W = CW + FPW_STRIDE_W + 6;
    localparam int OCC_W = FPW_QCNT_W + 1;

    logic                   accept;
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic [PY_W-1:0]        prod_y_reg;
    logic [PY_W-1:0]        prod_y_next;
    logic [PX_W-1:0]        prod_x_reg;
    logic [PX_W-1:0]        prod_x_next;
    logic [FPW_LEVEL_W-1:0] red_reg;
    logic [FPW_LEVEL_W-1:0] green_reg;
    logic [FPW_LEVEL_W-1:0] blue_reg;
    logic [OFF_W-1:0]       offset_full;
    logic [OFF_W-1:0]       end_full;
    fpw_status_t            status;

    // Items already in the multiply stage hold a queue slot in advance.
    assign full   = (OCC_W'(q_count) + OCC_W'(s1_valid_reg)) >= OCC_W'(FPW_QDEPTH);
    assign accept = push && !full;

    assign s1_valid_next = accept;
    assign prod_y_next   = PY_W'(pos_y[CW-1:0]) * PY_W'(cfg.line_stride_bytes);
    assign prod_x_next   = PX_W'(pos_x[CW-1:0]) * PX_W'(cfg.pixel_bytes);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_y_reg <= prod_y_next;
            prod_x_reg <= prod_x_next;
            red_reg    <= red_level;
            green_reg  <= green_level;
            blue_reg   <= blue_level;
        end
    end

    assign offset_full = OFF_W'(prod_y_reg) + OFF_W'(prod_x_reg);
    assign end_full    = offset_full + OFF_W'(cfg.pixel_bytes);

    always_comb
    begin
        if (!cfg.frame_present)
        begin
            status = ST_NO_FRAME;
        end
        else if (end_full > OFF_W'(cfg.buffer_size_bytes))
        begin
            status = ST_BOUNDS;
        end
        else if (cfg.format_mode == FMT_NONE)
        begin
            status = ST_FORMAT;
        end
        else
        begin
            status = ST_OK;
        end
    end

    always_comb
    begin
        q_data.offset = (status == ST_OK) ? offset_full[FPW_WORD_W-1:0] : '0;
        q_data.status = status;
        q_data.red    = red_reg;
        q_data.green  = green_reg;
        q_data.blue   = blue_reg;
    end

    assign q_push = s1_valid_reg;

endmodule

@@ hdl/fpw_back.sv @@
`include "assert_macros.svh"

module fpw_back
    import fpw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  fpw_cfg_t              cfg,
    input  logic                  q_valid,
    input  fpw_req_t              q_data,
    output logic                  q_pop,
    output logic                  empty,
    input  logic                  pop,
    output logic [FPW_WORD_W-1:0] byte_offset,
    output logic [FPW_WORD_W-1:0] pixel_word,
    output logic [FPW_WORD_W-1:0] write_bits,
    output logic [1:0]            status
);

    typedef logic [FPW_WORD_W-1:0][3:0] fpw_rank_t;

    // Rank of each mask bit among the set bits below it, saturated at eight.
    function automatic logic [3:0] rank_of(input logic [FPW_WORD_W-1:0] mask, input int pos);
        logic [FPW_WORD_W-1:0] below;
        int                    cnt;
        below = mask & ((FPW_WORD_W'(1) << pos) - FPW_WORD_W'(1));
        cnt   = $countones(below);
        return (cnt > FPW_LEVEL_W) ? 4'd8 : 4'(cnt);
    endfunction

    function automatic logic [FPW_WORD_W-1:0] deposit(input logic [FPW_LEVEL_W-1:0] level,
                                                      input logic [FPW_WORD_W-1:0] mask,
                                                      input fpw_rank_t rank);
        logic [FPW_WORD_W-1:0] word;
        word = '0;
        for (int i = 0; i < FPW_WORD_W; i++)
        begin
            word[i] = mask[i] & ~rank[i][3] & level[rank[i][2:0]];
        end
        return word;
    endfunction

    fpw_rank_t             rank_r_reg;
    fpw_rank_t             rank_r_next;
    fpw_rank_t             rank_g_reg;
    fpw_rank_t             rank_g_next;
    fpw_rank_t             rank_b_reg;
    fpw_rank_t             rank_b_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [FPW_WORD_W-1:0] offset_reg;
    logic [FPW_WORD_W-1:0] word_reg;
    logic [FPW_WORD_W-1:0] word_next;
    logic [FPW_WORD_W-1:0] bits_reg;
    logic [FPW_WORD_W-1:0] bits_next;
    fpw_status_t           status_reg;
    logic [FPW_WORD_W-1:0] dep_r;
    logic [FPW_WORD_W-1:0] dep_g;
    logic [FPW_WORD_W-1:0] dep_b;
    logic                  load;

    // The rank tables are registered from the masks; a transaction passes the
    // multiply stage and the queue before it reaches this stage.
    always_comb
    begin
        for (int i = 0; i < FPW_WORD_W; i++)
        begin
            rank_r_next[i] = rank_of(cfg.red_bit_mask, i);
            rank_g_next[i] = rank_of(cfg.green_bit_mask, i);
            rank_b_next[i] = rank_of(cfg.blue_bit_mask, i);
        end
    end

    always_ff @(posedge clk)
    begin
        rank_r_reg <= rank_r_next;
        rank_g_reg <= rank_g_next;
        rank_b_reg <= rank_b_next;
    end

    assign dep_r = deposit(q_data.red, cfg.red_bit_mask, rank_r_reg);
    assign dep_g = deposit(q_data.green, cfg.green_bit_mask, rank_g_reg);
    assign dep_b = deposit(q_data.blue, cfg.blue_bit_mask, rank_b_reg);

    always_comb
    begin
        word_next = '0;
        bits_next = '0;
        if (q_data.status == ST_OK)
        begin
            unique case (cfg.format_mode)
                FMT_BGR:
                begin
                    word_next = {8'h00, q_data.red, q_data.green, q_data.blue};
                    bits_next = '1;
                end
                FMT_RGB:
                begin
                    word_next = {8'h00, q_data.blue, q_data.green, q_data.red};
                    bits_next = '1;
                end
                FMT_MASK:
                begin
                    word_next = (((dep_r & ~cfg.green_bit_mask) | dep_g) & ~cfg.blue_bit_mask)
                                | dep_b;
                    bits_next = cfg.red_bit_mask | cfg.green_bit_mask | cfg.blue_bit_mask;
                end
                default:
                begin
                    word_next = '0;
                    bits_next = '0;
                end
            endcase
        end
    end

    assign load           = q_valid && (!out_valid_reg || pop);
    assign q_pop          = load;
    assign out_valid_next = load || (out_valid_reg && !pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            offset_reg <= q_data.offset;
            word_reg   <= word_next;
            bits_reg   <= bits_next;
            status_reg <= q_data.status;
        end
    end

    assign empty       = !out_valid_reg;
    assign byte_offset = offset_reg;
    assign pixel_word  = word_reg;
    assign write_bits  = bits_reg;
    assign status      = status_reg;

    `ASSERT_CLK_RST(a_pop_has_data, clk, rst_n, q_pop |-> q_valid,
        "Queue read without a waiting transaction.")
    `ASSERT_CLK_RST(a_reject_word, clk, rst_n,
        (out_valid_reg && (status_reg != ST_OK)) |-> ((word_reg == '0) && (bits_reg == '0)),
        "Rejected transaction carries pixel data.")
    `ASSERT_CLK_RST(a_reject_offset, clk, rst_n,
        (out_valid_reg && (status_reg != ST_OK)) |-> (offset_reg == '0),
        "Rejected transaction carries an offset.")
    `ASSERT_NEXT(a_load_valid, clk, rst_n, load, out_valid_reg,
        "Loaded result not shown.")

endmodule

@@ hdl/framebuffer_pixel_write_formatter_core.sv @@
// Framebuffer pixel write formatter.
// Input side is a queue: a transaction is taken at a rising edge with push high
// and full low; it carries pos_x, pos_y and the red, green and blue levels.
// Result side is a queue: while empty is low the oldest result is on byte_offset,
// pixel_word, write_bits and status, and pop at a rising edge takes it.
// Registers are written through cfg_valid, cfg_index and cfg_data; cfg_ready is
// always high. The user must make writes only while no transaction is in flight;
// the block itself does not enforce this. A transaction passes the multiply
// stage, is classified into a four-entry queue, then is formatted into the
// output register. One transaction per cycle is sustained while pop is held high;
// the rate is set by the single multiply stage and the output register, each
// taking one transaction per cycle.
// When pop stays low the output register holds its result, the queue fills,
// and full rises once the queue and the multiply stage hold four transactions.
// Reset empties the pipeline and loads the register defaults: no frame,
// four bytes per pixel, BGR format, all sizes and masks zero.
module framebuffer_pixel_write_formatter_core
    import fpw_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [FPW_POS_W-1:0]   pos_x,
    input  logic [FPW_POS_W-1:0]   pos_y,
    input  logic [FPW_LEVEL_W-1:0] red_level,
    input  logic [FPW_LEVEL_W-1:0] green_level,
    input  logic [FPW_LEVEL_W-1:0] blue_level,
    output logic                   empty,
    input  logic                   pop,
    output logic [FPW_WORD_W-1:0]  byte_offset,
    output logic [FPW_WORD_W-1:0]  pixel_word,
    output logic [FPW_WORD_W-1:0]  write_bits,
    output logic [1:0]             status,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [FPW_INDEX_W-1:0] cfg_index,
    input  logic [FPW_WORD_W-1:0]  cfg_data
);

    fpw_cfg_t              cfg_reg;
    fpw_cfg_t              cfg_next;
    logic                  q_push;
    logic                  q_pop;
    logic                  q_valid;
    fpw_req_t              q_wdata;
    fpw_req_t              q_rdata;
    logic [FPW_QCNT_W-1:0] q_count;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FRAME_PRESENT: cfg_next.frame_present     = cfg_data[0];
                REG_LINE_STRIDE:   cfg_next.line_stride_bytes = cfg_data[FPW_STRIDE_W-1:0];
                REG_PIXEL_BYTES:   cfg_next.pixel_bytes       = cfg_data[FPW_PB_W-1:0];
                REG_BUFFER_SIZE:   cfg_next.buffer_size_bytes = cfg_data;
                REG_FORMAT_MODE:   cfg_next.format_mode       = fpw_format_t'(cfg_data[1:0]);
                REG_RED_MASK:      cfg_next.red_bit_mask      = cfg_data;
                REG_GREEN_MASK:    cfg_next.green_bit_mask    = cfg_data;
                REG_BLUE_MASK:     cfg_next.blue_bit_mask     = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= FPW_CFG_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    fpw_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .push        (push),
        .full        (full),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .red_level   (red_level),
        .green_level (green_level),
        .blue_level  (blue_level),
        .q_count     (q_count),
        .q_push      (q_push),
        .q_data      (q_wdata)
    );

    fpw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wdata     (q_wdata),
        .pop       (q_pop),
        .rdata     (q_rdata),
        .not_empty (q_valid),
        .count     (q_count)
    );

    fpw_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_valid     (q_valid),
        .q_data      (q_rdata),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .byte_offset (byte_offset),
        .pixel_word  (pixel_word),
        .write_bits  (write_bits),
        .status      (status)
    );

endmodule
